FILE: rtl/core/bhsa_pkg.sv
package bhsa_pkg;

    // field widths
    localparam int IDX_W      = 25;
    localparam int ADDR_W     = 25;
    localparam int COORD_W    = 10;
    localparam int EXT_W      = 9;
    localparam int SIZE_W     = 9;
    localparam int HALO_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TERM_W     = 12;

    // restoring divide steps done in one pipeline stage
    localparam int DIV_STEPS  = 5;

    // pipeline depth: two dividers over the index width, then three address stages
    localparam int DIV_STAGES  = (IDX_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int ADDR_STAGES = 3;
    localparam int PIPE_DEPTH  = 2 * DIV_STAGES + ADDR_STAGES;

    // parameter defaults
    localparam int MAX_LOCAL_SIZE_DEF = 256;
    localparam int MAX_HALO_DEF       = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_I_MIN    = 3'd0,
        REG_BOX_J_MIN    = 3'd1,
        REG_BOX_K_MIN    = 3'd2,
        REG_BOX_J_EXTENT = 3'd3,
        REG_BOX_K_EXTENT = 3'd4,
        REG_HALO_WIDTH   = 3'd5,
        REG_LOCAL_J_SIZE = 3'd6,
        REG_LOCAL_K_SIZE = 3'd7
    } cfg_reg_t;

    // box configuration used by the datapath
    typedef struct packed {
        logic signed [COORD_W-1:0] box_i_min;
        logic signed [COORD_W-1:0] box_j_min;
        logic signed [COORD_W-1:0] box_k_min;
        logic        [EXT_W-1:0]   box_j_extent;
        logic        [EXT_W-1:0]   box_k_extent;
    } bhsa_cfg_t;

    // results of both dividers for one item
    typedef struct packed {
        logic [COORD_W-1:0] q2_lo;   // i offset, low bits
        logic [EXT_W-1:0]   r2;      // j offset
        logic [EXT_W-1:0]   r1;      // k offset
        logic [COORD_W-1:0] q1_lo;   // index over k extent, low bits
        logic [COORD_W-1:0] idx_lo;  // raw index, low bits
    } bhsa_div_res_t;

    // largest padded span along one axis
    function automatic int span_max(int max_local, int max_halo);
        int loc;
        int hal;
        loc = (max_local < 511) ? max_local : 511;
        hal = (max_halo < 15) ? max_halo : 15;
        return loc + 2 * hal;
    endfunction

    function automatic int span_width(int max_local, int max_halo);
        return $clog2(span_max(max_local, max_halo) + 1);
    endfunction

endpackage

FILE: rtl/core/bhsa_cfg_if.sv
interface bhsa_cfg_if;
    import bhsa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/bhsa_index_if.sv
interface bhsa_index_if;
    import bhsa_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] iteration_index;

    modport source (output valid, output iteration_index, input ready);
    modport sink   (input valid, input iteration_index, output ready);
endinterface

FILE: rtl/core/bhsa_site_if.sv
interface bhsa_site_if;
    import bhsa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_i;
    logic signed [COORD_W-1:0] coord_j;
    logic signed [COORD_W-1:0] coord_k;
    logic        [ADDR_W-1:0]  site_address;

    modport source (output valid, output coord_i, output coord_j, output coord_k,
                    output site_address, input ready);
    modport sink   (input valid, input coord_i, input coord_j, input coord_k,
                    input site_address, output ready);
endinterface

FILE: rtl/core/bhsa_cfg_regs.sv
module bhsa_cfg_regs #(
    parameter int MAX_LOCAL_SIZE = bhsa_pkg::MAX_LOCAL_SIZE_DEF,
    parameter int MAX_HALO       = bhsa_pkg::MAX_HALO_DEF,
    parameter int SPAN_W         = bhsa_pkg::span_width(MAX_LOCAL_SIZE, MAX_HALO),
    parameter int XS_W           = 2 * SPAN_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_valid,
    output logic                            wr_ready,
    input  logic [bhsa_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bhsa_pkg::CFG_DATA_W-1:0] wr_data,
    output bhsa_pkg::bhsa_cfg_t             cfg,
    output logic [bhsa_pkg::HALO_W-1:0]     halo,
    output logic [SPAN_W-1:0]               ys,
    output logic [XS_W-1:0]                 xs
);
    import bhsa_pkg::*;

    bhsa_cfg_t         box_reg;
    logic [HALO_W-1:0] halo_width_reg;
    logic [SIZE_W-1:0] local_j_size_reg;
    logic [SIZE_W-1:0] local_k_size_reg;

    logic [HALO_W-1:0] halo_sat;
    logic [SPAN_W-1:0] j_sat;
    logic [SPAN_W-1:0] k_sat;
    logic [SPAN_W-1:0] halo_span;

    logic [HALO_W-1:0] halo_reg;
    logic [SPAN_W-1:0] ys_reg;
    logic [SPAN_W-1:0] js_reg;
    logic [XS_W-1:0]   xs_reg;

    cfg_reg_t wr_sel;

    assign wr_ready = 1'b1;
    assign wr_sel   = cfg_reg_t'(wr_index);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.box_i_min    <= COORD_W'(1);
            box_reg.box_j_min    <= COORD_W'(1);
            box_reg.box_k_min    <= COORD_W'(1);
            box_reg.box_j_extent <= EXT_W'(1);
            box_reg.box_k_extent <= EXT_W'(1);
            halo_width_reg       <= HALO_W'(1);
            local_j_size_reg     <= SIZE_W'(1);
            local_k_size_reg     <= SIZE_W'(1);
        end
        else if (wr_valid)
        begin
            unique case (wr_sel)
                REG_BOX_I_MIN:    box_reg.box_i_min    <= wr_data[COORD_W-1:0];
                REG_BOX_J_MIN:    box_reg.box_j_min    <= wr_data[COORD_W-1:0];
                REG_BOX_K_MIN:    box_reg.box_k_min    <= wr_data[COORD_W-1:0];
                REG_BOX_J_EXTENT: box_reg.box_j_extent <= wr_data[EXT_W-1:0];
                REG_BOX_K_EXTENT: box_reg.box_k_extent <= wr_data[EXT_W-1:0];
                REG_HALO_WIDTH:   halo_width_reg       <= wr_data[HALO_W-1:0];
                REG_LOCAL_J_SIZE: local_j_size_reg     <= wr_data[SIZE_W-1:0];
                REG_LOCAL_K_SIZE: local_k_size_reg     <= wr_data[SIZE_W-1:0];
            endcase
        end
    end

    // saturate halo and sizes
    assign halo_sat  = (int'(halo_width_reg) > MAX_HALO) ? HALO_W'(MAX_HALO) : halo_width_reg;
    assign j_sat     = (int'(local_j_size_reg) > MAX_LOCAL_SIZE) ? SPAN_W'(MAX_LOCAL_SIZE)
                                                                 : SPAN_W'(local_j_size_reg);
    assign k_sat     = (int'(local_k_size_reg) > MAX_LOCAL_SIZE) ? SPAN_W'(MAX_LOCAL_SIZE)
                                                                 : SPAN_W'(local_k_size_reg);
    assign halo_span = SPAN_W'({halo_sat, 1'b0});

    // padded strides, registered in two steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halo_reg <= HALO_W'(1);
            ys_reg   <= SPAN_W'(3);
            js_reg   <= SPAN_W'(3);
            xs_reg   <= XS_W'(9);
        end
        else
        begin
            halo_reg <= halo_sat;
            ys_reg   <= k_sat + halo_span;
            js_reg   <= j_sat + halo_span;
            xs_reg   <= XS_W'(ys_reg) * XS_W'(js_reg);
        end
    end

    assign cfg  = box_reg;
    assign halo = halo_reg;
    assign ys   = ys_reg;
    assign xs   = xs_reg;

endmodule

FILE: rtl/core/bhsa_div_pipe.sv
module bhsa_div_pipe #(
    parameter int NUM_W  = bhsa_pkg::IDX_W,
    parameter int DEN_W  = bhsa_pkg::EXT_W,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [DEN_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NUM_W-1:0]  quotient,
    output logic [DEN_W-1:0]  remainder,
    output logic [SIDE_W-1:0] side_out
);
    import bhsa_pkg::*;

    localparam int STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   adv;
    logic [DEN_W-1:0]  rem_reg  [STAGES];
    logic [NUM_W-1:0]  nq_reg   [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];

    assign adv[STAGES] = out_ready;
    assign in_ready    = adv[0];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            logic              valid_in;
            logic [DEN_W-1:0]  rem_in;
            logic [NUM_W-1:0]  nq_in;
            logic [SIDE_W-1:0] side_s;
            logic [DEN_W-1:0]  rem_next;
            logic [NUM_W-1:0]  nq_next;

            // stage input: the port for the first stage, the previous stage otherwise
            if (s == 0)
            begin : g_first
                assign valid_in = in_valid;
                assign rem_in   = '0;
                assign nq_in    = dividend;
                assign side_s   = side_in;
            end
            else
            begin : g_next
                assign valid_in = valid_reg[s-1];
                assign rem_in   = rem_reg[s-1];
                assign nq_in    = nq_reg[s-1];
                assign side_s   = side_reg[s-1];
            end

            // stage moves when empty or when the next one moves
            assign adv[s] = !valid_reg[s] || adv[s+1];

            // restoring divide steps, quotient bits shift in behind the dividend
            always_comb
            begin : p_step
                logic [DEN_W:0]   trial;
                logic [DEN_W-1:0] r;
                logic [NUM_W-1:0] nq;
                r     = rem_in;
                nq    = nq_in;
                trial = '0;
                for (int b = 0; b < DIV_STEPS; b++)
                begin
                    if (s * DIV_STEPS + b < NUM_W)
                    begin
                        trial = {r, nq[NUM_W-1]};
                        nq    = {nq[NUM_W-2:0], 1'b0};
                        if (trial >= {1'b0, divisor})
                        begin
                            trial = trial - {1'b0, divisor};
                            nq[0] = 1'b1;
                        end
                        r = trial[DEN_W-1:0];
                    end
                end
                rem_next = r;
                nq_next  = nq;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (adv[s])
                    valid_reg[s] <= valid_in;
            end

            always_ff @(posedge clk)
            begin
                if (adv[s])
                begin
                    rem_reg[s]  <= rem_next;
                    nq_reg[s]   <= nq_next;
                    side_reg[s] <= side_s;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[STAGES-1];
    assign quotient  = nq_reg[STAGES-1];
    assign remainder = rem_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

FILE: rtl/core/bhsa_addr_gen.sv
module bhsa_addr_gen #(
    parameter int SPAN_W = 9,
    parameter int XS_W   = 2 * SPAN_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bhsa_pkg::bhsa_div_res_t             res,
    input  bhsa_pkg::bhsa_cfg_t                 cfg,
    input  logic [bhsa_pkg::HALO_W-1:0]         halo,
    input  logic [SPAN_W-1:0]                   ys,
    input  logic [XS_W-1:0]                     xs,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bhsa_pkg::COORD_W-1:0] coord_i,
    output logic signed [bhsa_pkg::COORD_W-1:0] coord_j,
    output logic signed [bhsa_pkg::COORD_W-1:0] coord_k,
    output logic [bhsa_pkg::ADDR_W-1:0]         site_address
);
    import bhsa_pkg::*;

    logic adv1;
    logic adv2;
    logic adv3;

    logic [COORD_W-1:0] off_i;
    logic [COORD_W-1:0] off_j;
    logic [COORD_W-1:0] off_k;
    logic               k_zero;
    logic               j_zero;

    logic signed [TERM_W-1:0] term_i;
    logic signed [TERM_W-1:0] term_j;
    logic signed [TERM_W-1:0] term_k;
    logic signed [TERM_W-1:0] halo_term;

    logic                      v1_reg;
    logic signed [COORD_W-1:0] ci1_reg;
    logic signed [COORD_W-1:0] cj1_reg;
    logic signed [COORD_W-1:0] ck1_reg;

    logic                      v2_reg;
    logic signed [COORD_W-1:0] ci2_reg;
    logic signed [COORD_W-1:0] cj2_reg;
    logic signed [COORD_W-1:0] ck2_reg;
    logic [ADDR_W-1:0]         pi_reg;
    logic [ADDR_W-1:0]         pj_reg;
    logic [ADDR_W-1:0]         pk_reg;

    logic                      v3_reg;
    logic signed [COORD_W-1:0] ci3_reg;
    logic signed [COORD_W-1:0] cj3_reg;
    logic signed [COORD_W-1:0] ck3_reg;
    logic [ADDR_W-1:0]         addr3_reg;

    // stall chain
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // offsets, with the empty-extent cases
    assign k_zero = (cfg.box_k_extent == '0);
    assign j_zero = (cfg.box_j_extent == '0);
    assign off_k  = k_zero ? res.idx_lo : COORD_W'(res.r1);
    assign off_j  = k_zero ? '0 : (j_zero ? res.q1_lo : COORD_W'(res.r2));
    assign off_i  = (k_zero || j_zero) ? '0 : res.q2_lo;

    // stage 1: coordinates
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            ci1_reg <= cfg.box_i_min + off_i;
            cj1_reg <= cfg.box_j_min + off_j;
            ck1_reg <= cfg.box_k_min + off_k;
        end
    end

    // padded-array terms h + c - 1
    assign halo_term = $signed({{(TERM_W-HALO_W){1'b0}}, halo});
    assign term_i    = halo_term + TERM_W'(ci1_reg) - TERM_W'(1);
    assign term_j    = halo_term + TERM_W'(cj1_reg) - TERM_W'(1);
    assign term_k    = halo_term + TERM_W'(ck1_reg) - TERM_W'(1);

    // stage 2: stride products, modulo the address width
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            ci2_reg <= ci1_reg;
            cj2_reg <= cj1_reg;
            ck2_reg <= ck1_reg;
            pi_reg  <= ADDR_W'(xs) * ADDR_W'(term_i);
            pj_reg  <= ADDR_W'(ys) * ADDR_W'(term_j);
            pk_reg  <= ADDR_W'(term_k);
        end
    end

    // stage 3: sum into the output register
    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            ci3_reg   <= ci2_reg;
            cj3_reg   <= cj2_reg;
            ck3_reg   <= ck2_reg;
            addr3_reg <= pi_reg + pj_reg + pk_reg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    assign out_valid    = v3_reg;
    assign coord_i      = ci3_reg;
    assign coord_j      = cj3_reg;
    assign coord_k      = ck3_reg;
    assign site_address = addr3_reg;

endmodule

FILE: rtl/core/box_index_to_halo_site_address_top.sv
// pipeline: an accepted item passes two 5-stage divider pipelines
// of 5 restoring steps each, then 3 stages for coordinates, stride products and sum
// throughput: one item per cycle while the output is ready; stages advance
// independently so bubbles close up under output back-pressure
// reset: clears all valid bits and loads every box register with 1; strides follow
// a register write through the ys and js registers and then the xs register
module box_index_to_halo_site_address_top #(
    parameter int MAX_LOCAL_SIZE = bhsa_pkg::MAX_LOCAL_SIZE_DEF,
    parameter int MAX_HALO       = bhsa_pkg::MAX_HALO_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    bhsa_cfg_if.sink           cfg,
    bhsa_index_if.sink         box_index,
    bhsa_site_if.source        site
);
    import bhsa_pkg::*;

    localparam int SPAN_W = span_width(MAX_LOCAL_SIZE, MAX_HALO);
    localparam int XS_W   = 2 * SPAN_W;
    localparam int SIDE2_W = EXT_W + 2 * COORD_W;

    bhsa_cfg_t         box_cfg;
    logic [HALO_W-1:0] halo;
    logic [SPAN_W-1:0] ys;
    logic [XS_W-1:0]   xs;

    logic               d1_valid;
    logic               d1_ready;
    logic [IDX_W-1:0]   d1_quot;
    logic [EXT_W-1:0]   d1_rem;
    logic [COORD_W-1:0] d1_idx_lo;

    logic               d2_valid;
    logic               d2_ready;
    logic [IDX_W-1:0]   d2_quot;
    logic [EXT_W-1:0]   d2_rem;
    logic [SIDE2_W-1:0] d2_side;

    bhsa_div_res_t      div_res;

    // configuration registers and padded strides
    bhsa_cfg_regs #(
        .MAX_LOCAL_SIZE (MAX_LOCAL_SIZE),
        .MAX_HALO       (MAX_HALO),
        .SPAN_W         (SPAN_W),
        .XS_W           (XS_W)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (box_cfg),
        .halo     (halo),
        .ys       (ys),
        .xs       (xs)
    );

    // index split by the k extent
    bhsa_div_pipe #(
        .NUM_W  (IDX_W),
        .DEN_W  (EXT_W),
        .SIDE_W (COORD_W)
    ) u_div_k (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (box_index.valid),
        .in_ready  (box_index.ready),
        .dividend  (box_index.iteration_index),
        .divisor   (box_cfg.box_k_extent),
        .side_in   (box_index.iteration_index[COORD_W-1:0]),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .quotient  (d1_quot),
        .remainder (d1_rem),
        .side_out  (d1_idx_lo)
    );

    // row index split by the j extent
    bhsa_div_pipe #(
        .NUM_W  (IDX_W),
        .DEN_W  (EXT_W),
        .SIDE_W (SIDE2_W)
    ) u_div_j (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .dividend  (d1_quot),
        .divisor   (box_cfg.box_j_extent),
        .side_in   ({d1_rem, d1_quot[COORD_W-1:0], d1_idx_lo}),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .quotient  (d2_quot),
        .remainder (d2_rem),
        .side_out  (d2_side)
    );

    assign div_res.q2_lo  = d2_quot[COORD_W-1:0];
    assign div_res.r2     = d2_rem;
    assign div_res.r1     = d2_side[SIDE2_W-1 -: EXT_W];
    assign div_res.q1_lo  = d2_side[2*COORD_W-1 -: COORD_W];
    assign div_res.idx_lo = d2_side[COORD_W-1:0];

    // coordinates and address
    bhsa_addr_gen #(
        .SPAN_W (SPAN_W),
        .XS_W   (XS_W)
    ) u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (d2_valid),
        .in_ready     (d2_ready),
        .res          (div_res),
        .cfg          (box_cfg),
        .halo         (halo),
        .ys           (ys),
        .xs           (xs),
        .out_valid    (site.valid),
        .out_ready    (site.ready),
        .coord_i      (site.coord_i),
        .coord_j      (site.coord_j),
        .coord_k      (site.coord_k),
        .site_address (site.site_address)
    );

endmodule

FILE: rtl/core/bhsa_checker.sv
module bhsa_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [bhsa_pkg::COORD_W-1:0] coord_i,
    input logic signed [bhsa_pkg::COORD_W-1:0] coord_j,
    input logic signed [bhsa_pkg::COORD_W-1:0] coord_k,
    input logic [bhsa_pkg::ADDR_W-1:0]         site_address
);
    import bhsa_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] count_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // items in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (in_acc && !out_acc)
            count_reg <= count_reg + CNT_W'(1);
        else if (out_acc && !in_acc)
            count_reg <= count_reg - CNT_W'(1);
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coord_i) && $stable(coord_j)
            && $stable(coord_k) && $stable(site_address))
        else $error("stalled result changed");

    // a taken output frees the whole pipeline to accept
    a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is taken");

    // no result without an item in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != '0)
        else $error("result without an accepted item");

    // never more items in flight than pipeline stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more items in flight than stages");

endmodule

bind box_index_to_halo_site_address_top bhsa_checker u_bhsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (box_index.valid),
    .in_ready     (box_index.ready),
    .out_valid    (site.valid),
    .out_ready    (site.ready),
    .coord_i      (site.coord_i),
    .coord_j      (site.coord_j),
    .coord_k      (site.coord_k),
    .site_address (site.site_address)
);

FILE: tb/box_index_to_halo_site_address_top_test.sv
`timescale 1ns / 100ps

module box_index_to_halo_site_address_top_test;
    import bhsa_pkg::*;

    // pipeline depth plus margin, used before register writes and at the end
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 4;
    localparam int HALO_CAP     = MAX_HALO_DEF;
    localparam int SIZE_CAP     = MAX_LOCAL_SIZE_DEF;

    typedef struct {
        logic signed [COORD_W-1:0] ci;
        logic signed [COORD_W-1:0] cj;
        logic signed [COORD_W-1:0] ck;
        logic        [ADDR_W-1:0]  addr;
    } site_item_t;

    logic clk;
    logic rst_n;
    logic steady;
    int   mismatch_count;

    // box registers as the block should hold them
    logic signed [COORD_W-1:0] i_min;
    logic signed [COORD_W-1:0] j_min;
    logic signed [COORD_W-1:0] k_min;
    logic        [EXT_W-1:0]   j_ext;
    logic        [EXT_W-1:0]   k_ext;
    logic        [HALO_W-1:0]  halo;
    logic        [SIZE_W-1:0]  j_size;
    logic        [SIZE_W-1:0]  k_size;

    // sites still owed by the block, oldest first
    site_item_t pending_sites[$];

    bhsa_cfg_if   cfg_ch();
    bhsa_index_if index_ch();
    bhsa_site_if  site_ch();

    box_index_to_halo_site_address_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_ch),
        .box_index (index_ch),
        .site      (site_ch)
    );

    // clock
    always #5 clk = ~clk;

    // split the index row-major and form the padded array address
    function automatic site_item_t locate_site(logic [IDX_W-1:0] idx);
        longint unsigned plane;
        longint unsigned off_i;
        longint unsigned off_j;
        longint unsigned off_k;
        longint unsigned rem_jk;
        longint          h;
        longint          jsz;
        longint          ksz;
        longint          ys;
        longint          xs;
        longint          padded;
        site_item_t      s;
        plane = 64'(j_ext) * 64'(k_ext);
        if (plane == 0)
        begin
            off_i  = 0;
            rem_jk = 64'(idx);
        end
        else
        begin
            off_i  = 64'(idx) / plane;
            rem_jk = 64'(idx) % plane;
        end
        if (k_ext == 0)
        begin
            off_j = 0;
            off_k = rem_jk;
        end
        else
        begin
            off_j = rem_jk / 64'(k_ext);
            off_k = rem_jk % 64'(k_ext);
        end
        s.ci = i_min + off_i[COORD_W-1:0];
        s.cj = j_min + off_j[COORD_W-1:0];
        s.ck = k_min + off_k[COORD_W-1:0];
        // oversized halo and sizes clamp before the strides
        h   = longint'(halo);
        jsz = longint'(j_size);
        ksz = longint'(k_size);
        if (h > HALO_CAP)
            h = HALO_CAP;
        if (jsz > SIZE_CAP)
            jsz = SIZE_CAP;
        if (ksz > SIZE_CAP)
            ksz = SIZE_CAP;
        ys = ksz + 2 * h;
        xs = ys * (jsz + 2 * h);
        padded = xs * (h + longint'(s.ci) - 1) + ys * (h + longint'(s.cj) - 1)
               + (h + longint'(s.ck) - 1);
        s.addr = padded[ADDR_W-1:0];
        return s;
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        site_ch.ready <= steady || ($urandom_range(99) >= 16);
    end

    task automatic report_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // compare each delivered site with the oldest one owed
    always @(posedge clk)
    begin
        site_item_t want;
        if (rst_n && site_ch.valid && site_ch.ready)
        begin
            if (pending_sites.size() == 0)
            begin
                $display("%0t: unexpected site item, expected none, actual address %0d",
                         $time, site_ch.site_address);
                mismatch_count++;
            end
            else
            begin
                want = pending_sites.pop_front();
                report_field("coord_i", longint'(want.ci), longint'(site_ch.coord_i));
                report_field("coord_j", longint'(want.cj), longint'(site_ch.coord_j));
                report_field("coord_k", longint'(want.ck), longint'(site_ch.coord_k));
                report_field("site_address", longint'(want.addr),
                             longint'(site_ch.site_address));
            end
        end
    end

    // send one index item, with random gaps ahead of it
    task automatic send_index(logic [IDX_W-1:0] idx);
        while (!steady && $urandom_range(99) < 16)
        begin
            index_ch.valid <= 1'b0;
            @(posedge clk);
        end
        index_ch.valid           <= 1'b1;
        index_ch.iteration_index <= idx;
        do
            @(posedge clk);
        while (!index_ch.ready);
        pending_sites.push_back(locate_site(idx));
    endtask

    // stop sending and let every owed site come out
    task automatic wait_idle();
        index_ch.valid <= 1'b0;
        while (pending_sites.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= d;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    // write all box registers, block must be idle
    task automatic load_box(int imin, int jmin, int kmin, int jx, int kx,
                            int hw, int js, int ks);
        wait_idle();
        i_min  = COORD_W'(imin);
        j_min  = COORD_W'(jmin);
        k_min  = COORD_W'(kmin);
        j_ext  = EXT_W'(jx);
        k_ext  = EXT_W'(kx);
        halo   = HALO_W'(hw);
        j_size = SIZE_W'(js);
        k_size = SIZE_W'(ks);
        write_reg(REG_BOX_I_MIN, i_min);
        write_reg(REG_BOX_J_MIN, j_min);
        write_reg(REG_BOX_K_MIN, k_min);
        write_reg(REG_BOX_J_EXTENT, CFG_DATA_W'(j_ext));
        write_reg(REG_BOX_K_EXTENT, CFG_DATA_W'(k_ext));
        write_reg(REG_HALO_WIDTH, CFG_DATA_W'(halo));
        write_reg(REG_LOCAL_J_SIZE, CFG_DATA_W'(j_size));
        write_reg(REG_LOCAL_K_SIZE, CFG_DATA_W'(k_size));
        cfg_ch.valid <= 1'b0;
    endtask

    // realistic box and lattice, returns the number of sites in the box
    task automatic load_typical_box(output int unsigned box_sites);
        int unsigned i_count;
        int unsigned jx;
        int unsigned kx;
        i_count = $urandom_range(1, 16);
        jx      = $urandom_range(1, 272);
        kx      = $urandom_range(1, 272);
        load_box(int'($urandom_range(271)) - 7, int'($urandom_range(271)) - 7,
                 int'($urandom_range(271)) - 7, jx, kx, $urandom_range(1, 8),
                 $urandom_range(1, 256), $urandom_range(1, 256));
        box_sites = i_count * jx * kx;
    endtask

    // mostly sites inside the box, some box edges, some arbitrary indices
    task automatic send_box_items(int n, int unsigned box_sites);
        int unsigned pick;
        logic [IDX_W-1:0] idx;
        for (int n_sent = 0; n_sent < n; n_sent++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                idx = IDX_W'($urandom_range(box_sites - 1));
            else if (pick < 85)
                idx = IDX_W'(box_sites - 1);
            else
                idx = IDX_W'($urandom);
            send_index(idx);
        end
    endtask

    // reset values, including a coordinate that wraps
    task automatic test_reset_defaults();
        send_index('0);
        send_index(IDX_W'(1));
        send_index({IDX_W{1'b1}});
    endtask

    // register extremes and each special case
    task automatic test_corner_boxes();
        // largest extents, halo and sizes above their caps
        load_box(-512, 511, -7, 511, 511, 15, 511, 511);
        send_index('0);
        send_index(IDX_W'(511 * 511 - 1));
        send_index({IDX_W{1'b1}});
        // zero j extent, the quotient by the k extent becomes the j offset
        load_box(0, 0, 0, 0, 5, 1, 256, 256);
        send_index('0);
        send_index(IDX_W'(7));
        send_index({IDX_W{1'b1}});
        // zero k extent
        load_box(264, -7, 264, 3, 0, 8, 1, 1);
        send_index(IDX_W'(10));
        send_index(IDX_W'(1000));
        // zero halo and zero sizes, the padded address can go negative and wrap
        load_box(0, 0, 0, 2, 2, 0, 0, 0);
        send_index('0);
        send_index(IDX_W'(5));
        // small box, walking over the i boundary and past the box
        load_box(1, 1, 1, 4, 3, 2, 4, 3);
        send_index('0);
        send_index(IDX_W'(2));
        send_index(IDX_W'(11));
        send_index(IDX_W'(12));
        send_index(IDX_W'(13));
    endtask

    // several realistic boxes with random indices
    task automatic test_random_boxes();
        int unsigned box_sites;
        for (int phase = 0; phase < 5; phase++)
        begin
            load_typical_box(box_sites);
            send_box_items(120, box_sites);
        end
    endtask

    // full width register values, zero extents now and then
    task automatic test_random_registers();
        for (int phase = 0; phase < 3; phase++)
        begin
            load_box($urandom, $urandom, $urandom,
                     ($urandom_range(3) == 0) ? 0 : $urandom,
                     ($urandom_range(3) == 0) ? 0 : $urandom,
                     $urandom, $urandom, $urandom);
            for (int n_sent = 0; n_sent < 50; n_sent++)
                send_index(IDX_W'($urandom));
        end
    endtask

    // no gaps on either side
    task automatic test_full_rate();
        int unsigned box_sites;
        load_typical_box(box_sites);
        steady = 1'b1;
        send_box_items(150, box_sites);
        wait_idle();
        steady = 1'b0;
    endtask

    initial
    begin
        clk                      = 1'b0;
        rst_n                    = 1'b0;
        steady                   = 1'b0;
        mismatch_count           = 0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = '0;
        cfg_ch.data              = '0;
        index_ch.valid           = 1'b0;
        index_ch.iteration_index = '0;
        site_ch.ready            = 1'b0;
        i_min  = 1;
        j_min  = 1;
        k_min  = 1;
        j_ext  = 1;
        k_ext  = 1;
        halo   = 1;
        j_size = 1;
        k_size = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_corner_boxes();
        test_random_boxes();
        test_random_registers();
        test_full_rate();

        wait_idle();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
